>>> src/sksw_pkg.sv
`timescale 1ns / 1ps
package sksw_pkg;

  // Key mask bit positions
  localparam int KEY_W = 0;
  localparam int KEY_S = 1;
  localparam int KEY_A = 2;
  localparam int KEY_D = 3;
  localparam int KEY_E = 7;

  localparam int STICK_CENTRE    = 1024;
  localparam int FULL_DEFLECTION = 660;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_NORMAL_SPEED = 3'd0;
  localparam logic [2:0] REG_HIGH_SPEED   = 3'd1;
  localparam logic [2:0] REG_MAX_WHEEL    = 3'd2;
  localparam logic [2:0] REG_DEADBAND     = 3'd3;
  localparam logic [2:0] REG_RAMP_STEP    = 3'd4;

  // Reciprocal for floor(n / 3), exact for n < 2**13
  localparam int THIRD_SHIFT = 14;
  localparam logic [12:0] THIRD_RECIP = 13'(((1 << THIRD_SHIFT) + 2) / 3);

  // Reciprocal for floor(n / 660), exact for n < 2**30
  localparam int WDIV_SHIFT = 40;
  localparam logic [63:0] WDIV_RECIP_FULL =
    ((64'd1 << WDIV_SHIFT) + 64'(FULL_DEFLECTION - 1)) / 64'(FULL_DEFLECTION);
  localparam logic [30:0] WDIV_RECIP = WDIV_RECIP_FULL[30:0];

  // Ramped axes never leave +/-4094, so 13 magnitude bits are plenty
  localparam int MAG_W = 13;

  typedef struct packed {
    logic [10:0] normal_speed;
    logic [10:0] high_speed;
    logic [13:0] max_wheel_speed;
    logic [9:0]  ramp_deadband;
    logic [9:0]  ramp_step;
  } sksw_cfg_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } sksw_vec_t;

endpackage

>>> src/sksw_front.sv
`timescale 1ns / 1ps
module sksw_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [10:0]         in_stick_x,
  input  logic [10:0]         in_stick_y,
  input  logic [15:0]         in_key_mask,
  input  sksw_pkg::sksw_cfg_t cfg,
  input  logic                q_full,
  output logic                q_push,
  output sksw_pkg::sksw_vec_t q_vec
);
  import sksw_pkg::*;

  logic signed [15:0] ramped_x_r, ramped_x_nxt;
  logic signed [15:0] ramped_y_r, ramped_y_nxt;
  logic signed [12:0] tgt_x, tgt_y;
  logic signed [12:0] base_x, base_y;
  logic [10:0]        key_spd;
  logic               slow;

  function automatic logic signed [15:0] ramp_next(
    input logic signed [12:0] tgt,
    input logic signed [15:0] now,
    input logic               quirk,
    input sksw_cfg_t          c
  );
    logic signed [17:0] err;
    logic [17:0]        aerr;
    logic [11:0]        tmag;
    logic [25:0]        tq;
    logic signed [17:0] stepped;
    logic signed [15:0] res;
    err  = 18'(tgt) - 18'(now);
    aerr = err[17] ? 18'(-err) : 18'(err);
    tmag = tgt[12] ? 12'(-tgt) : 12'(tgt);
    tq   = 26'(tmag) * 26'(THIRD_RECIP);
    if (err[17]) begin
      stepped = 18'(now) - $signed({8'd0, c.ramp_step});
    end else begin
      stepped = 18'(now) + $signed({8'd0, c.ramp_step});
    end
    priority if (aerr < 18'(c.ramp_deadband)) begin
      res = 16'(tgt);
    end else if (quirk && tgt[12] && (aerr > 18'(c.high_speed))) begin
      res = 16'd0 - 16'(tq[25:THIRD_SHIFT]);
    end else if (err == 18'sd0) begin
      res = now;
    end else if (stepped > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (stepped < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = stepped[15:0];
    end
    return res;
  endfunction

  // Build targets: slow mode uses keys alone, else centred sticks plus key boost
  always_comb begin
    slow    = in_key_mask[KEY_E];
    key_spd = slow ? cfg.normal_speed : cfg.high_speed;
    base_x  = slow ? 13'sd0 : ($signed({2'b00, in_stick_x}) - 13'(STICK_CENTRE));
    base_y  = slow ? 13'sd0 : ($signed({2'b00, in_stick_y}) - 13'(STICK_CENTRE));
    tgt_x   = base_x;
    tgt_y   = base_y;
    if (in_key_mask[KEY_D] && !in_key_mask[KEY_A]) begin
      tgt_x = base_x + $signed({2'b00, key_spd});
    end else if (in_key_mask[KEY_A] && !in_key_mask[KEY_D]) begin
      tgt_x = base_x - $signed({2'b00, key_spd});
    end
    if (in_key_mask[KEY_W] && !in_key_mask[KEY_S]) begin
      tgt_y = base_y + $signed({2'b00, key_spd});
    end else if (in_key_mask[KEY_S] && !in_key_mask[KEY_W]) begin
      tgt_y = base_y - $signed({2'b00, key_spd});
    end
    ramped_x_nxt = ramp_next(tgt_x, ramped_x_r, 1'b1, cfg);
    ramped_y_nxt = ramp_next(tgt_y, ramped_y_r, 1'b0, cfg);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_vec    = '{x: ramped_x_nxt, y: ramped_y_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramped_x_r <= '0;
      ramped_y_r <= '0;
    end else if (q_push) begin
      ramped_x_r <= ramped_x_nxt;
      ramped_y_r <= ramped_y_nxt;
    end
  end

endmodule

>>> src/sksw_fifo.sv
`timescale 1ns / 1ps
module sksw_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sksw_pkg::sksw_vec_t push_vec,
  output logic                full,
  input  logic                pop,
  output logic                not_empty,
  output sksw_pkg::sksw_vec_t pop_vec
);
  import sksw_pkg::*;

  sksw_vec_t   mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_vec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> src/sksw_back.sv
`timescale 1ns / 1ps
module sksw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  sksw_pkg::sksw_cfg_t cfg,
  input  logic                q_not_empty,
  input  sksw_pkg::sksw_vec_t q_vec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_left_front_speed,
  output logic signed [15:0]  out_right_front_speed,
  output logic signed [15:0]  out_left_rear_speed,
  output logic signed [15:0]  out_right_rear_speed
);
  import sksw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_R2A, ST_R2B, ST_NUM, ST_SQ, ST_ROOT, ST_WMUL, ST_WDIV, ST_OUT
  } state_t;

  state_t                   state_r;
  logic signed [MAG_W:0]    x_r, y_r;
  logic [MAG_W-1:0]         ax_r, ay_r, m_r;
  logic [2*MAG_W:0]         r2_r;
  logic [2*MAG_W:0]         p_r;
  logic [2*MAG_W:0]         num_r;
  logic [53:0]              sq_r;
  logic [59:0]              t_r, v_r, a_r;
  logic [15:0]              q_r;
  logic [3:0]               bit_r;
  logic [29:0]              n_r;
  logic                     pass_r, neg_r;
  logic signed [15:0]       sum_acc_r, diff_acc_r;
  logic signed [15:0]       w_sum_r, w_diff_r;
  logic                     out_valid_r;

  logic [30:0]              mul_a, mul_b;
  logic [61:0]              prod;
  logic signed [MAG_W+1:0]  s;
  logic [MAG_W:0]           as;
  logic [59:0]              cand;
  logic [21:0]              wmag;
  logic signed [15:0]       wval;

  // One shared multiplier, operands picked by state
  always_comb begin
    s = pass_r ? ((MAG_W+2)'(y_r) - (MAG_W+2)'(x_r))
               : ((MAG_W+2)'(y_r) + (MAG_W+2)'(x_r));
    as = s[MAG_W+1] ? (MAG_W+1)'(-s) : (MAG_W+1)'(s);
    unique case (state_r)
      ST_R2A:  begin mul_a = 31'(ax_r);  mul_b = 31'(ax_r);  end
      ST_R2B:  begin mul_a = 31'(ay_r);  mul_b = 31'(ay_r);  end
      ST_NUM:  begin mul_a = 31'(m_r);   mul_b = 31'(as);    end
      ST_SQ:   begin mul_a = 31'(num_r); mul_b = 31'(num_r); end
      ST_WMUL: begin mul_a = 31'(q_r);   mul_b = 31'(cfg.max_wheel_speed); end
      ST_WDIV: begin mul_a = 31'(n_r);   mul_b = WDIV_RECIP; end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
    prod = 62'(mul_a) * 62'(mul_b);
    cand = t_r + v_r + a_r;
    wmag = prod[WDIV_SHIFT +: 22];
    if (neg_r) begin
      wval = (wmag > 22'd32768) ? 16'sh8000 : (16'd0 - wmag[15:0]);
    end else begin
      wval = (wmag > 22'd32767) ? 16'sh7FFF : wmag[15:0];
    end
  end

  assign q_pop     = (state_r == ST_IDLE) && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_left_front_speed  = w_sum_r;
  assign out_right_rear_speed  = w_sum_r;
  assign out_right_front_speed = w_diff_r;
  assign out_left_rear_speed   = w_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_not_empty) begin
            x_r     <= q_vec.x[MAG_W:0];
            y_r     <= q_vec.y[MAG_W:0];
            ax_r    <= q_vec.x[15] ? MAG_W'(-q_vec.x) : MAG_W'(q_vec.x);
            ay_r    <= q_vec.y[15] ? MAG_W'(-q_vec.y) : MAG_W'(q_vec.y);
            pass_r  <= 1'b0;
            state_r <= ST_R2A;
          end
        end
        ST_R2A: begin
          p_r     <= prod[2*MAG_W:0];
          m_r     <= (ay_r > ax_r) ? ay_r : ax_r;
          state_r <= ST_R2B;
        end
        ST_R2B: begin
          r2_r    <= p_r + prod[2*MAG_W:0];
          state_r <= ST_NUM;
        end
        ST_NUM: begin
          num_r   <= prod[2*MAG_W:0];
          neg_r   <= s[MAG_W+1];
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          sq_r    <= prod[53:0];
          t_r     <= '0;
          v_r     <= '0;
          a_r     <= 60'(r2_r) << 30;
          q_r     <= '0;
          bit_r   <= 4'd15;
          state_r <= ST_ROOT;
        end
        // Largest q with q*q*r2 <= sq, one bit a cycle, squares kept incrementally
        ST_ROOT: begin
          if (cand <= 60'(sq_r)) begin
            t_r        <= cand;
            v_r        <= (v_r >> 1) + a_r;
            q_r[bit_r] <= 1'b1;
          end else begin
            v_r <= v_r >> 1;
          end
          a_r <= a_r >> 2;
          if (bit_r == 4'd0) state_r <= ST_WMUL;
          bit_r <= bit_r - 4'd1;
        end
        ST_WMUL: begin
          n_r     <= (r2_r == '0) ? 30'd0 : prod[29:0];
          state_r <= ST_WDIV;
        end
        ST_WDIV: begin
          if (pass_r) begin
            diff_acc_r <= wval;
            state_r    <= ST_OUT;
          end else begin
            sum_acc_r  <= wval;
            pass_r     <= 1'b1;
            state_r    <= ST_NUM;
          end
        end
        // Hold the pending word until the output register is free
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            w_sum_r     <= sum_acc_r;
            w_diff_r    <= diff_acc_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/stick_keys_to_wheel_speeds_top.sv
`timescale 1ns / 1ps
// Stick and key mask to four mecanum wheel speeds.
// Input channel (in_valid / in_stall): one word per control tick with the two
// 11-bit stick channels and the 16-bit key mask. The front end takes a word,
// forms the X/Y targets, advances the ramp state and drops the ramped vector
// into a two-entry queue; it stalls only when that queue is full.
// The back end pops one vector at a time and runs the mixer on a single shared
// multiplier: two squares, then for the sum and difference terms a product, a
// square, a 16-step bit-serial root/divide search and a scale by max/660.
// Output channel (out_valid / out_stall): one word of four speeds per input
// word, held in an output register until taken; a stalled word stays put while
// the back end finishes the next vector and then waits.
// The back end sequencer sets the sustained rate: it runs two mixer passes per
// vector and pops the next vector only once it is back in idle.
// Reset (rst_n, synchronous) clears both ramped axes, empties the queue and
// loads the register defaults: 300, 660, 8000, 66, 6.
// Configuration: APB, register i at byte 4*i, written on psel&penable&pwrite.
module stick_keys_to_wheel_speeds_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [10:0]        in_stick_x,
  input  logic [10:0]        in_stick_y,
  input  logic [15:0]        in_key_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_left_front_speed,
  output logic signed [15:0] out_right_front_speed,
  output logic signed [15:0] out_left_rear_speed,
  output logic signed [15:0] out_right_rear_speed,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import sksw_pkg::*;

  sksw_cfg_t  cfg_r;
  logic       q_push, q_full, q_pop, q_not_empty;
  sksw_vec_t  push_vec, pop_vec;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register file: mask to field width, ignore writes past the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.normal_speed    <= 11'd300;
      cfg_r.high_speed      <= 11'd660;
      cfg_r.max_wheel_speed <= 14'd8000;
      cfg_r.ramp_deadband   <= 10'd66;
      cfg_r.ramp_step       <= 10'd6;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_NORMAL_SPEED: cfg_r.normal_speed    <= cfg_pwdata[10:0];
        REG_HIGH_SPEED:   cfg_r.high_speed      <= cfg_pwdata[10:0];
        REG_MAX_WHEEL:    cfg_r.max_wheel_speed <= cfg_pwdata[13:0];
        REG_DEADBAND:     cfg_r.ramp_deadband   <= cfg_pwdata[9:0];
        REG_RAMP_STEP:    cfg_r.ramp_step       <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NORMAL_SPEED: cfg_prdata = 32'(cfg_r.normal_speed);
      REG_HIGH_SPEED:   cfg_prdata = 32'(cfg_r.high_speed);
      REG_MAX_WHEEL:    cfg_prdata = 32'(cfg_r.max_wheel_speed);
      REG_DEADBAND:     cfg_prdata = 32'(cfg_r.ramp_deadband);
      REG_RAMP_STEP:    cfg_prdata = 32'(cfg_r.ramp_step);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  sksw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_stick_x  (in_stick_x),
    .in_stick_y  (in_stick_y),
    .in_key_mask (in_key_mask),
    .cfg         (cfg_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_vec       (push_vec)
  );

  sksw_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_vec  (push_vec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_vec   (pop_vec)
  );

  sksw_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg                   (cfg_r),
    .q_not_empty           (q_not_empty),
    .q_vec                 (pop_vec),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_left_front_speed  (out_left_front_speed),
    .out_right_front_speed (out_right_front_speed),
    .out_left_rear_speed   (out_left_rear_speed),
    .out_right_rear_speed  (out_right_rear_speed)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sksw_pkg::*;

  logic clk;
  logic rst_n;

  // Input channel
  logic        in_valid;
  logic        in_stall;
  logic [10:0] in_stick_x;
  logic [10:0] in_stick_y;
  logic [15:0] in_key_mask;

  // Result channel
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_left_front_speed;
  logic signed [15:0] out_right_front_speed;
  logic signed [15:0] out_left_rear_speed;
  logic signed [15:0] out_right_rear_speed;

  // Configuration port
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  typedef struct packed {
    logic [10:0] stick_x;
    logic [10:0] stick_y;
    logic [15:0] key_mask;
  } tick_word_t;

  typedef struct packed {
    logic signed [15:0] lf;
    logic signed [15:0] rf;
    logic signed [15:0] lr;
    logic signed [15:0] rr;
  } wheel_word_t;

  // Pending ticks for the driver, and wheel words still owed by the block
  tick_word_t  tick_queue[$];
  wheel_word_t wheel_queue[$];

  // Own copy of the block's registers and ramp state
  int unsigned normal_spd, high_spd, max_wheel, deadband, ramp_inc;
  int          axis_x, axis_y;

  int  error_count;
  bit  in_idle_ok;
  bit  out_idle_ok;
  bit  out_hold;
  int  hold_count;
  bit  hold_req;

  stick_keys_to_wheel_speeds_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Advance one axis towards its target; the X axis carries the thirds quirk
  function automatic int step_axis(int target, int now, bit x_axis);
    longint diff;
    longint adiff;
    diff  = longint'(target) - longint'(now);
    adiff = diff < 0 ? -diff : diff;
    if (adiff < deadband) return target;
    if (x_axis && target < 0 && adiff > high_spd) return target / 3;
    if (diff > 0) return int'(clamp16(longint'(now) + ramp_inc));
    if (diff < 0) return int'(clamp16(longint'(now) - ramp_inc));
    return now;
  endfunction

  // trunc(m*|s|/sqrt(r2)) by bitwise search, signed as s
  function automatic longint mix_term(longint m, longint s, longint unsigned r2);
    longint unsigned num;
    longint unsigned sq;
    longint unsigned q;
    longint unsigned c;
    num = longint'(m) * (s < 0 ? -s : s);
    sq  = num * num;
    q   = 0;
    for (int b = 15; b >= 0; b--) begin
      c = q | (64'd1 << b);
      if (c * c * r2 <= sq) q = c;
    end
    return s < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [15:0] scale_wheel(longint pwm);
    return 16'(clamp16(pwm * longint'(max_wheel) / FULL_DEFLECTION));
  endfunction

  function automatic wheel_word_t predict_wheels(tick_word_t t);
    int tx, ty, dx, dy;
    longint x, y, ax, ay, m, p_sum, p_diff;
    longint unsigned r2;
    wheel_word_t w;
    dx = int'(t.key_mask[KEY_D]) - int'(t.key_mask[KEY_A]);
    dy = int'(t.key_mask[KEY_W]) - int'(t.key_mask[KEY_S]);
    if (t.key_mask[KEY_E]) begin
      tx = dx * int'(normal_spd);
      ty = dy * int'(normal_spd);
    end else begin
      tx = int'(t.stick_x) - STICK_CENTRE + dx * int'(high_spd);
      ty = int'(t.stick_y) - STICK_CENTRE + dy * int'(high_spd);
    end
    axis_x = step_axis(tx, axis_x, 1'b1);
    axis_y = step_axis(ty, axis_y, 1'b0);
    x  = axis_x;
    y  = axis_y;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    m  = ay > ax ? ay : ax;
    r2 = ax * ax + ay * ay;
    if (r2 == 0) begin
      p_sum  = 0;
      p_diff = 0;
    end else begin
      p_sum  = mix_term(m, y + x, r2);
      p_diff = mix_term(m, y - x, r2);
    end
    w.lf = scale_wheel(p_sum);
    w.rf = scale_wheel(p_diff);
    w.lr = w.rf;
    w.rr = w.lf;
    return w;
  endfunction

  // Driver: offer the head of the tick queue, advance on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        wheel_queue.push_back(predict_wheels({in_stick_x, in_stick_y, in_key_mask}));
        void'(tick_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (tick_queue.size() > 0 &&
                   (!in_idle_ok || $urandom_range(99) >= 25)) begin
        in_valid    <= 1'b1;
        in_stick_x  <= tick_queue[0].stick_x;
        in_stick_y  <= tick_queue[0].stick_y;
        in_key_mask <= tick_queue[0].key_mask;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block fills and stalls its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_count <= 0;
      out_hold   <= 1'b0;
    end else if (hold_req && !out_hold && hold_count == 0) begin
      out_hold   <= 1'b1;
      hold_count <= 600;
    end else if (hold_count > 1) begin
      hold_count <= hold_count - 1;
    end else if (hold_count == 1) begin
      hold_count <= 0;
      out_hold   <= 1'b0;
    end
  end

  // Monitor: stall at random, compare each taken word with the oldest prediction
  always @(posedge clk) begin
    wheel_word_t exp_w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (wheel_queue.size() == 0) begin
          $error("unexpected wheel word");
          error_count++;
        end else begin
          exp_w = wheel_queue.pop_front();
          if (out_left_front_speed !== exp_w.lf) begin
            $error("left_front_speed exp %0d got %0d", exp_w.lf, out_left_front_speed);
            error_count++;
          end
          if (out_right_front_speed !== exp_w.rf) begin
            $error("right_front_speed exp %0d got %0d", exp_w.rf, out_right_front_speed);
            error_count++;
          end
          if (out_left_rear_speed !== exp_w.lr) begin
            $error("left_rear_speed exp %0d got %0d", exp_w.lr, out_left_rear_speed);
            error_count++;
          end
          if (out_right_rear_speed !== exp_w.rr) begin
            $error("right_rear_speed exp %0d got %0d", exp_w.rr, out_right_rear_speed);
            error_count++;
          end
        end
      end
      out_stall <= out_hold || (out_idle_ok && $urandom_range(99) < 25);
    end
  end

  // Write one register: setup cycle then access cycle
  task automatic write_reg(logic [2:0] idx, int unsigned value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_NORMAL_SPEED: normal_spd = value & 32'h7FF;
      REG_HIGH_SPEED:   high_spd   = value & 32'h7FF;
      REG_MAX_WHEEL:    max_wheel  = value & 32'h3FFF;
      REG_DEADBAND:     deadband   = value & 32'h3FF;
      REG_RAMP_STEP:    ramp_inc   = value & 32'h3FF;
      default: ;
    endcase
  endtask

  task automatic set_all(int unsigned ns, int unsigned hs, int unsigned mw,
                         int unsigned db, int unsigned rs);
    write_reg(REG_NORMAL_SPEED, ns);
    write_reg(REG_HIGH_SPEED, hs);
    write_reg(REG_MAX_WHEEL, mw);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_RAMP_STEP, rs);
  endtask

  task automatic add_tick(logic [10:0] sx, logic [10:0] sy, logic [15:0] keys);
    tick_queue.push_back({sx, sy, keys});
  endtask

  // Mostly driving-like sequences: held stick positions and key combinations
  task automatic add_random(int count);
    logic [10:0] sx, sy;
    logic [15:0] keys;
    int run;
    run = 0;
    for (int i = 0; i < count; i++) begin
      if (run == 0) begin
        run = $urandom_range(40, 1);
        case ($urandom_range(3))
          0: begin
            sx = 11'($urandom_range(1684, 364));
            sy = 11'($urandom_range(1684, 364));
          end
          1: begin
            sx = 11'($urandom);
            sy = 11'($urandom);
          end
          2: begin
            sx = 11'd1024;
            sy = 11'd1024;
          end
          default: begin
            sx = $urandom_range(1) ? 11'd2047 : 11'd0;
            sy = $urandom_range(1) ? 11'd2047 : 11'd0;
          end
        endcase
        keys = 16'($urandom);
        if ($urandom_range(1)) keys &= 16'h008F;
      end
      run--;
      add_tick(sx, sy, keys);
    end
  endtask

  // Wait for every owed word plus the back end's latency
  task automatic drain();
    while (tick_queue.size() != 0 || in_valid || wheel_queue.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_stick_x  = '0;
    in_stick_y  = '0;
    in_key_mask = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    error_count = 0;
    in_idle_ok  = 1'b1;
    out_idle_ok = 1'b1;
    hold_req    = 1'b0;
    normal_spd  = 300;
    high_spd    = 660;
    max_wheel   = 8000;
    deadband    = 66;
    ramp_inc    = 6;
    axis_x      = 0;
    axis_y      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: stick extremes, centre, every key, slow mode, the thirds quirk
    add_tick(11'd1024, 11'd1024, 16'h0000);
    add_tick(11'd0, 11'd0, 16'h0000);
    add_tick(11'd2047, 11'd2047, 16'h0000);
    add_tick(11'd0, 11'd2047, 16'h0000);
    add_tick(11'd2047, 11'd0, 16'h0000);
    add_tick(11'd1024, 11'd1024, 16'h0001);
    add_tick(11'd1024, 11'd1024, 16'h0002);
    add_tick(11'd1024, 11'd1024, 16'h0004);
    add_tick(11'd1024, 11'd1024, 16'h0008);
    add_tick(11'd1024, 11'd1024, 16'h0081);
    add_tick(11'd1024, 11'd1024, 16'h0086);
    add_tick(11'd0, 11'd0, 16'h0084);
    add_tick(11'd0, 11'd0, 16'h0006);
    add_tick(11'd0, 11'd0, 16'hFF7F);
    add_tick(11'd2047, 11'd2047, 16'hFFFF);
    add_tick(11'd1030, 11'd1020, 16'h0000);
    add_tick(11'd1024, 11'd1024, 16'h0000);
    drain();

    // Extremes of the registers, then a large ramp step to hit saturation
    set_all(32'h7FF, 32'h7FF, 32'h3FFF, 0, 32'h3FF);
    add_tick(11'd2047, 11'd2047, 16'h0009);
    add_tick(11'd2047, 11'd2047, 16'h0009);
    add_tick(11'd0, 11'd0, 16'h0006);
    add_tick(11'd0, 11'd0, 16'h0006);
    add_tick(11'd1024, 11'd1024, 16'h008F);
    add_random(180);
    drain();

    set_all(0, 0, 0, 32'h3FF, 0);
    add_random(150);
    drain();

    set_all(32'hFFFF_FFFF, 1, 1, 1, 1);
    add_random(150);
    drain();

    // Long receiver hold-off while the sender keeps offering
    set_all(300, 660, 8000, 66, 6);
    in_idle_ok  = 1'b0;
    out_idle_ok = 1'b0;
    hold_req    = 1'b1;
    add_random(200);
    wait (out_hold);
    hold_req = 1'b0;
    drain();
    in_idle_ok  = 1'b1;
    out_idle_ok = 1'b1;

    set_all($urandom_range(2047), $urandom_range(2047), $urandom_range(16383),
            $urandom_range(200), $urandom_range(300));
    add_random(440);
    drain();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Slowest run: ~1200 words, random gaps and stalls, hold-off
  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
